FILE: sv/lgw_pkg.sv
package lgw_pkg;

	localparam int GRID_COLUMNS = 4;
	localparam int GRID_ROWS    = 4;
	localparam int WAVE_PERIOD  = 64;

	localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
	localparam int COL_W      = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
	localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int PHASE_W    = $clog2(WAVE_PERIOD);

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_FLOOR   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_PEAK    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_DELAY  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_DELAY     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_BASE      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_INCREMENT = 3'd5;

	localparam logic [7:0]  RST_LEVEL_FLOOR   = 8'd0;
	localparam logic [7:0]  RST_LEVEL_PEAK    = 8'd255;
	localparam logic [5:0]  RST_COLUMN_DELAY  = 6'd4;
	localparam logic [5:0]  RST_ROW_DELAY     = 6'd2;
	localparam logic [15:0] RST_HUE_BASE      = 16'd0;
	localparam logic [15:0] RST_HUE_INCREMENT = 16'd16;

	localparam logic [7:0] ENVELOPE_ROM [WAVE_PERIOD] = '{
		8'd0,   8'd1,   8'd2,   8'd5,   8'd10,  8'd15,  8'd21,  8'd29,
		8'd37,  8'd47,  8'd57,  8'd67,  8'd79,  8'd90,  8'd103, 8'd115,
		8'd127, 8'd140, 8'd152, 8'd165, 8'd176, 8'd188, 8'd198, 8'd208,
		8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
		8'd255, 8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226,
		8'd218, 8'd208, 8'd198, 8'd188, 8'd176, 8'd165, 8'd152, 8'd140,
		8'd128, 8'd115, 8'd103, 8'd90,  8'd79,  8'd67,  8'd57,  8'd47,
		8'd37,  8'd29,  8'd21,  8'd15,  8'd10,  8'd5,   8'd2,   8'd1
	};

	typedef struct packed {
		logic [7:0]  level_floor;
		logic [7:0]  level_peak;
		logic [5:0]  column_delay;
		logic [5:0]  row_delay;
		logic [15:0] hue_base;
		logic [15:0] hue_increment;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [PHASE_W-1:0] step;
		logic [PHASE_W-1:0] lag;
		logic [15:0]        hue;
	} geom_t;

endpackage

FILE: sv/lgw_cfg_regs.sv
module lgw_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lgw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lgw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output lgw_pkg::cfg_t                    cfg
);

	lgw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_floor   <= lgw_pkg::RST_LEVEL_FLOOR;
			cfg_q.level_peak    <= lgw_pkg::RST_LEVEL_PEAK;
			cfg_q.column_delay  <= lgw_pkg::RST_COLUMN_DELAY;
			cfg_q.row_delay     <= lgw_pkg::RST_ROW_DELAY;
			cfg_q.hue_base      <= lgw_pkg::RST_HUE_BASE;
			cfg_q.hue_increment <= lgw_pkg::RST_HUE_INCREMENT;
		end else if (cfg_write) begin
			case (cfg_index)
				lgw_pkg::REG_LEVEL_FLOOR:   cfg_q.level_floor   <= cfg_data[7:0];
				lgw_pkg::REG_LEVEL_PEAK:    cfg_q.level_peak    <= cfg_data[7:0];
				lgw_pkg::REG_COLUMN_DELAY:  cfg_q.column_delay  <= cfg_data[5:0];
				lgw_pkg::REG_ROW_DELAY:     cfg_q.row_delay     <= cfg_data[5:0];
				lgw_pkg::REG_HUE_BASE:      cfg_q.hue_base      <= cfg_data[15:0];
				lgw_pkg::REG_HUE_INCREMENT: cfg_q.hue_increment <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/lgw_geom.sv
module lgw_geom (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  lgw_pkg::cfg_t cfg,
	input  logic          in_valid,
	input  logic [7:0]    encoder_index,
	input  logic [15:0]   step_count,
	output lgw_pkg::geom_t geom
);

	localparam int CW = lgw_pkg::COL_W;
	localparam int RW = lgw_pkg::ROW_W;
	localparam int PW = lgw_pkg::PHASE_W;

	logic          in_range;
	logic [RW-1:0] row;
	logic [7:0]    col_full;
	logic [CW-1:0] col;

	logic          valid_s1;
	logic [CW-1:0] col_back_s1;
	logic [RW-1:0] row_back_s1;
	logic [7:0]    back_s1;
	logic [PW-1:0] step_s1;

	logic [CW+5:0] lag_col;
	logic [RW+5:0] lag_row;
	logic [23:0]   hue_prod;

	logic          valid_s2;
	logic [PW-1:0] lag_s2;
	logic [15:0]   hue_s2;
	logic [PW-1:0] step_s2;

	// row by compare against each row start, column by remainder
	always_comb begin
		row = '0;
		for (int r = 1; r < lgw_pkg::GRID_ROWS; r++) begin
			if ({1'b0, encoder_index} >= 9'(r * lgw_pkg::GRID_COLUMNS)) begin
				row = RW'(r);
			end
		end
		col_full = encoder_index - 8'(int'(row) * lgw_pkg::GRID_COLUMNS);
		col      = col_full[CW-1:0];
		in_range = {1'b0, encoder_index} < 9'(lgw_pkg::CELL_COUNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// out of range: zero lag and zero distance give lag 0 and the base hue
	always_ff @(posedge clk) begin
		if (adv) begin
			if (in_range) begin
				col_back_s1 <= CW'(lgw_pkg::GRID_COLUMNS - 1) - col;
				row_back_s1 <= RW'(lgw_pkg::GRID_ROWS - 1) - row;
				back_s1     <= 8'(lgw_pkg::CELL_COUNT - 1) - encoder_index;
			end else begin
				col_back_s1 <= '0;
				row_back_s1 <= '0;
				back_s1     <= '0;
			end
			step_s1 <= step_count[PW-1:0];
		end
	end

	always_comb begin
		lag_col  = {6'd0, col_back_s1} * {{CW{1'b0}}, cfg.column_delay};
		lag_row  = {6'd0, row_back_s1} * {{RW{1'b0}}, cfg.row_delay};
		hue_prod = {16'd0, back_s1} * {8'd0, cfg.hue_increment};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lag_s2  <= lag_col[PW-1:0] + lag_row[PW-1:0];
			hue_s2  <= cfg.hue_base + hue_prod[15:0];
			step_s2 <= step_s1;
		end
	end

	assign geom.valid = valid_s2;
	assign geom.step  = step_s2;
	assign geom.lag   = lag_s2;
	assign geom.hue   = hue_s2;

	a_col_back_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (int'(col_back_s1) <= lgw_pkg::GRID_COLUMNS - 1))
		else $error("column distance beyond grid");

	a_row_back_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (int'(row_back_s1) <= lgw_pkg::GRID_ROWS - 1))
		else $error("row distance beyond grid");

endmodule

FILE: sv/lgw_level.sv
module lgw_level (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  lgw_pkg::cfg_t  cfg,
	input  lgw_pkg::geom_t geom,
	output logic           out_valid,
	output logic [7:0]     brightness,
	output logic [15:0]    hue
);

	localparam int PW = lgw_pkg::PHASE_W;

	logic [PW-1:0] phase;
	logic [7:0]    span;
	logic [15:0]   quot_sum;

	logic          valid_s3;
	logic [7:0]    shape_s3;
	logic [15:0]   hue_s3;

	logic          valid_s4;
	logic [15:0]   prod_s4;
	logic [15:0]   hue_s4;

	logic          valid_s5;
	logic [7:0]    bright_s5;
	logic [15:0]   hue_s5;

	assign phase = geom.step - geom.lag;
	assign span  = (cfg.level_peak > cfg.level_floor) ? (cfg.level_peak - cfg.level_floor) : 8'd0;

	// divide by 255, exact for any product of two bytes
	assign quot_sum = prod_s4 + 16'd1 + {8'd0, prod_s4[15:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= geom.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			shape_s3  <= lgw_pkg::ENVELOPE_ROM[phase];
			hue_s3    <= geom.hue;
			prod_s4   <= {8'd0, shape_s3} * {8'd0, span};
			hue_s4    <= hue_s3;
			bright_s5 <= cfg.level_floor + quot_sum[15:8];
			hue_s5    <= hue_s4;
		end
	end

	assign out_valid  = valid_s5;
	assign brightness = bright_s5;
	assign hue        = hue_s5;

	a_prod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (prod_s4 <= 16'd65025))
		else $error("envelope product out of bounds");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && adv) |=> valid_s5)
		else $error("request lost between stages");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(valid_s3) && $stable(valid_s4) && $stable(hue_s5)))
		else $error("pipeline moved while frozen");

endmodule

FILE: sv/led_grid_wave_level_and_hue.sv
// an accepted request passes through the stage registers s1 to s5 to reach out_valid
// throughput: one request per cycle unless out_stall freezes the pipeline; the single pipeline enable sets it
// out_stall with a pending result freezes all five stages and raises in_stall
// reset clears the stage valid bits and loads the configuration registers' reset values
// the envelope table is constant logic and needs no clearing
module led_grid_wave_level_and_hue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [lgw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lgw_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      encoder_index,
	input  logic [15:0]                     step_count,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      brightness,
	output logic [15:0]                     hue
);

	lgw_pkg::cfg_t  cfg;
	lgw_pkg::geom_t geom;
	logic           adv;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	lgw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lgw_geom u_geom (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.encoder_index (encoder_index),
		.step_count    (step_count),
		.geom          (geom)
	);

	lgw_level u_level (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cfg        (cfg),
		.geom       (geom),
		.out_valid  (out_valid),
		.brightness (brightness),
		.hue        (hue)
	);

endmodule
